FILE: hw/rtl/tile_background_pixel_render_defines.svh
// ----------------------------------------------------------------------------
// tile_background_pixel_render_defines
// assertion macros used by the tbpr_pixel rtl
// ----------------------------------------------------------------------------
`ifndef TILE_BACKGROUND_PIXEL_RENDER_DEFINES_SVH
`define TILE_BACKGROUND_PIXEL_RENDER_DEFINES_SVH

// same-cycle implication
`define TBPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbpr assertion failed");

// next-cycle implication
`define TBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbpr assertion failed");

`endif

FILE: hw/rtl/tbpr_pkg.sv
// ----------------------------------------------------------------------------
// tbpr_pkg
// shared types and constants of the tile background pixel renderer
// ----------------------------------------------------------------------------
package tbpr_pkg;

  localparam int LINE_WIDTH = 160;

  localparam int VRAM_AW     = 13;
  localparam int REG_ADDR_W  = 5;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;

  // register indexes
  localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y    = 3'd1;
  localparam logic [2:0] REG_SCROLL_X    = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y    = 3'd3;
  localparam logic [2:0] REG_WINDOW_X    = 3'd4;
  localparam logic [2:0] REG_BG_PALETTE  = 3'd5;

  // request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_y;
    logic [7:0] scroll_x;
    logic [7:0] window_y;
    logic [7:0] window_x;
    logic [7:0] bg_palette;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         wdata;
  } mem_req_t;

endpackage

FILE: hw/rtl/tbpr_vram.sv
// ----------------------------------------------------------------------------
// tbpr_vram
// 8 KiB single-port video memory, registered read
// ----------------------------------------------------------------------------
module tbpr_vram (
  input  logic              clk_i,
  input  tbpr_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);
  import tbpr_pkg::*;

  logic [7:0] mem [2**VRAM_AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tbpr_cfg.sv
// ----------------------------------------------------------------------------
// tbpr_cfg
// apb register file for lcd control, scroll, window and palette
// ----------------------------------------------------------------------------
module tbpr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbpr_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tbpr_pkg::cfg_t                  cfg_o
);
  import tbpr_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[REG_ADDR_W-1:2];

  always_comb begin
    unique case (reg_idx)
      REG_LCD_CONTROL: rd_val = cfg_q.lcd_control;
      REG_SCROLL_Y:    rd_val = cfg_q.scroll_y;
      REG_SCROLL_X:    rd_val = cfg_q.scroll_x;
      REG_WINDOW_Y:    rd_val = cfg_q.window_y;
      REG_WINDOW_X:    rd_val = cfg_q.window_x;
      REG_BG_PALETTE:  rd_val = cfg_q.bg_palette;
      default:         rd_val = 8'h00;
    endcase
  end

  assign prdata = {24'h000000, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_control <= 8'h91;
      cfg_q.scroll_y    <= 8'h00;
      cfg_q.scroll_x    <= 8'h00;
      cfg_q.window_y    <= 8'h00;
      cfg_q.window_x    <= 8'h00;
      cfg_q.bg_palette  <= 8'hFC;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LCD_CONTROL: cfg_q.lcd_control <= pwdata[7:0];
        REG_SCROLL_Y:    cfg_q.scroll_y    <= pwdata[7:0];
        REG_SCROLL_X:    cfg_q.scroll_x    <= pwdata[7:0];
        REG_WINDOW_Y:    cfg_q.window_y    <= pwdata[7:0];
        REG_WINDOW_X:    cfg_q.window_x    <= pwdata[7:0];
        REG_BG_PALETTE:  cfg_q.bg_palette  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/tbpr_pixel.sv
// ----------------------------------------------------------------------------
// tbpr_pixel
// request sequencer: map fetch, two bitplane fetches, palette and output
// ----------------------------------------------------------------------------
`include "tile_background_pixel_render_defines.svh"

module tbpr_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tbpr_pkg::cfg_t                  cfg_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tbpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tbpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output tbpr_pkg::mem_req_t              mem_req_o,
  input  logic [7:0]                      mem_rdata_i
);
  import tbpr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_LO,
    ST_HI
  } state_e;

  state_e             state_q;
  logic               out_valid_q;
  logic [7:0]         gray_q, out_col_q, out_line_q;
  logic [7:0]         col_q, line_q;
  logic [2:0]         px_lo_q, py_lo_q;
  logic [VRAM_AW-1:0] row_addr_q;
  logic [7:0]         lo_q;

  logic [VRAM_AW-1:0] in_offset;
  logic [7:0]         in_data, in_col, in_line;
  logic               s_accept, out_free, in_range, start_render;
  logic [7:0]         win_start, px, py;
  logic               use_win, map_high;
  logic [VRAM_AW-1:0] map_base, map_addr, tile_addr, row_addr;
  logic [2:0]         bit_sel;
  logic [1:0]         cid, shade;
  logic [7:0]         gray;

  function automatic logic [7:0] shade_gray(input logic [1:0] s);
    logic [7:0] g;
    case (s)
      2'd0:    g = 8'd255;
      2'd1:    g = 8'd192;
      2'd2:    g = 8'd96;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

  assign in_offset = s_axis_tdata[12:0];
  assign in_data   = s_axis_tdata[20:13];
  assign in_col    = s_axis_tdata[28:21];
  assign in_line   = s_axis_tdata[36:29];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_HI) && out_free);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_range      = {1'b0, in_col} < 9'(LINE_WIDTH);
  assign start_render  = s_accept && (s_axis_tuser == KIND_RENDER) && in_range;

  // window or scrolled background coordinates
  always_comb begin
    win_start = cfg_i.window_x - 8'd7;
    use_win   = cfg_i.lcd_control[5] && (in_line >= cfg_i.window_y) &&
                (in_col >= win_start);
    if (use_win) begin
      px       = in_col - win_start;
      py       = in_line - cfg_i.window_y;
      map_high = cfg_i.lcd_control[6];
    end else begin
      px       = cfg_i.scroll_x + in_col;
      py       = cfg_i.scroll_y + in_line;
      map_high = cfg_i.lcd_control[3];
    end
    map_base = map_high ? 13'h1C00 : 13'h1800;
    map_addr = map_base + {3'b000, py[7:3], px[7:3]};
  end

  // tile data row address from the fetched tile index
  always_comb begin
    if (cfg_i.lcd_control[4]) begin
      tile_addr = {1'b0, mem_rdata_i, 4'b0000};
    end else begin
      tile_addr = 13'h0800 + {1'b0, mem_rdata_i ^ 8'h80, 4'b0000};
    end
    row_addr = tile_addr + {9'd0, py_lo_q, 1'b0};
  end

  always_comb begin
    bit_sel = ~px_lo_q;
    cid     = {mem_rdata_i[bit_sel], lo_q[bit_sel]};
    shade   = cfg_i.bg_palette[{cid, 1'b0} +: 2];
    gray    = shade_gray(shade);
  end

  always_comb begin
    mem_req_o = '0;
    unique case (state_q) inside
      ST_IDLE, ST_HI: begin
        if (s_accept && (s_axis_tuser == KIND_WRITE)) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = in_offset;
          mem_req_o.wdata = in_data;
        end else if (start_render) begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = map_addr;
        end
      end
      ST_MAP: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = row_addr;
      end
      ST_LO: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = row_addr_q | 13'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_render) begin
            state_q <= ST_MAP;
          end
        end
        ST_MAP: begin
          row_addr_q <= row_addr;
          state_q    <= ST_LO;
        end
        ST_LO: begin
          lo_q    <= mem_rdata_i;
          state_q <= ST_HI;
        end
        ST_HI: begin
          if (out_free) begin
            gray_q      <= gray;
            out_col_q   <= col_q;
            out_line_q  <= line_q;
            out_valid_q <= 1'b1;
            state_q     <= start_render ? ST_MAP : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (start_render) begin
        col_q   <= in_col;
        line_q  <= in_line;
        px_lo_q <= px[2:0];
        py_lo_q <= py[2:0];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_line_q, out_col_q, gray_q};

  `TBPR_ASSERT_IMPL(a_accept_slot, clk_i, rst_ni, s_accept, (state_q == ST_IDLE) || (state_q == ST_HI))
  `TBPR_ASSERT_IMPL(a_write_slot, clk_i, rst_ni, mem_req_o.we, (state_q == ST_IDLE) || (state_q == ST_HI))
  `TBPR_ASSERT_NEXT(a_map_to_lo, clk_i, rst_ni, state_q == ST_MAP, state_q == ST_LO)
  `TBPR_ASSERT_NEXT(a_result_load, clk_i, rst_ni, (state_q == ST_HI) && out_free, out_valid_q)

endmodule

FILE: hw/rtl/tile_background_pixel_render.sv
// ----------------------------------------------------------------------------
// tile_background_pixel_render
// render: map, low and high bitplane reads in turn on the single memory port;
// result registered in ST_HI once the output is free, next render taken there
// write: one per cycle while idle, else held for ST_HI as the port is busy
// reset: config registers to defaults, video memory content not cleared
// ----------------------------------------------------------------------------
module tile_background_pixel_render (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbpr_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // mem_offset[12:0], mem_data[20:13], column[28:21], line[36:29], zero pad
  input  logic [tbpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                            s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // gray_level[7:0], out_column[15:8], out_line[23:16]
  output logic [tbpr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tbpr_pkg::*;

  cfg_t       cfg;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  tbpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbpr_vram u_vram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tbpr_pixel u_pixel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams video memory writes and pixel render requests into the renderer,
// reprograms its registers over apb between phases and compares every
// rendered pixel with an in-bench model of the tile map and window fetch
// ----------------------------------------------------------------------------
module testbench;
  import tbpr_pkg::*;

  localparam logic [12:0] MAP_LOW_BASE  = 13'h1800;
  localparam logic [12:0] MAP_HIGH_BASE = 13'h1C00;
  localparam logic [12:0] SIGNED_BASE   = 13'h0800;
  localparam logic [7:0]  WIN_X_OFFSET  = 8'd7;
  localparam logic [7:0]  INDEX_BIAS    = 8'h80;
  localparam logic [31:0] SHADE_GRAY    = {8'd0, 8'd96, 8'd192, 8'd255};
  localparam int          LCDC_BG_MAP   = 3;
  localparam int          LCDC_UNSIGNED = 4;
  localparam int          LCDC_WIN_EN   = 5;
  localparam int          LCDC_WIN_MAP  = 6;
  localparam int          VRAM_DEPTH    = 8192;
  localparam int          NUM_REGS      = 6;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 50;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_AT       = 300;
  localparam int          CALM_FROM     = 450;
  localparam int          CALM_TO       = 650;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          IDLE_PCT      = 13;
  localparam int          MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] gray;
  } pixel_t;

  class render_book;
    logic [7:0] vram [VRAM_DEPTH];
    bit         written [VRAM_DEPTH];
    logic [7:0] regs [NUM_REGS];
    pixel_t     pixel_q [$];
    int         n_in, n_write, n_render, n_pixel, n_err, n_cfg;

    function new();
      regs[REG_LCD_CONTROL] = 8'h91;
      regs[REG_SCROLL_Y]    = 8'h00;
      regs[REG_SCROLL_X]    = 8'h00;
      regs[REG_WINDOW_Y]    = 8'h00;
      regs[REG_WINDOW_X]    = 8'h00;
      regs[REG_BG_PALETTE]  = 8'hFC;
    endfunction

    function void flag(string msg);
      n_err++;
      if (n_err <= MAX_REPORTS) $display("mismatch at %0t: %0s", $time, msg);
    endfunction

    // tile map byte, bitplane row address and bit position of one pixel
    function void locate(input logic [7:0] col, input logic [7:0] row,
                         output logic [12:0] map_a, output logic [12:0] row_a,
                         output logic [2:0] px_bit);
      logic [7:0]  lcdc, win_start, px, py, idx;
      logic [12:0] tile_off;
      lcdc = regs[REG_LCD_CONTROL];
      win_start = regs[REG_WINDOW_X] - WIN_X_OFFSET;
      if (lcdc[LCDC_WIN_EN] && row >= regs[REG_WINDOW_Y] && col >= win_start) begin
        px = col - win_start;
        py = row - regs[REG_WINDOW_Y];
        map_a = lcdc[LCDC_WIN_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
      end else begin
        px = regs[REG_SCROLL_X] + col;
        py = regs[REG_SCROLL_Y] + row;
        map_a = lcdc[LCDC_BG_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
      end
      map_a = map_a + {3'b000, py[7:3], 5'b00000} + {8'd0, px[7:3]};
      idx = written[map_a] ? vram[map_a] : 8'h00;
      if (lcdc[LCDC_UNSIGNED]) tile_off = {1'b0, idx, 4'b0000};
      else tile_off = SIGNED_BASE + {1'b0, idx ^ INDEX_BIAS, 4'b0000};
      row_a = tile_off + {9'd0, py[2:0], 1'b0};
      px_bit = 3'd7 - px[2:0];
    endfunction

    function void note(input logic kind, input logic [12:0] off, input logic [7:0] data,
                       input logic [7:0] col, input logic [7:0] row);
      logic [12:0] map_a, row_a;
      logic [2:0]  b;
      logic [1:0]  cid, shade;
      logic [7:0]  pal;
      pixel_t      p;
      n_in++;
      if (kind == KIND_WRITE) begin
        vram[off] = data;
        written[off] = 1'b1;
        n_write++;
      end else begin
        n_render++;
        if (int'(col) < LINE_WIDTH) begin
          locate(col, row, map_a, row_a, b);
          cid = {vram[row_a + 13'd1][b], vram[row_a][b]};
          pal = regs[REG_BG_PALETTE];
          shade = pal[{cid, 1'b0} +: 2];
          p.gray = SHADE_GRAY[{shade, 3'b000} +: 8];
          p.col = col;
          p.row = row;
          pixel_q.push_back(p);
        end
      end
    endfunction

    function void check(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        flag($sformatf("unexpected pixel gray %0d col %0d row %0d",
                       got.gray, got.col, got.row));
        return;
      end
      want = pixel_q.pop_front();
      n_pixel++;
      if (got.gray !== want.gray)
        flag($sformatf("gray_level expected %0d got %0d (col %0d row %0d)",
                       want.gray, got.gray, want.col, want.row));
      if (got.col !== want.col)
        flag($sformatf("out_column expected %0d got %0d", want.col, got.col));
      if (got.row !== want.row)
        flag($sformatf("out_line expected %0d got %0d", want.row, got.row));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  render_book book = new();
  int         stall_cycles = 0;
  int         hold_left = 0;
  bit         held = 1'b0;

  tile_background_pixel_render dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit calm();
    return book.n_in >= CALM_FROM && book.n_in < CALM_TO;
  endfunction

  task automatic send_req(input logic kind, input logic [12:0] off, input logic [7:0] data,
                          input logic [7:0] col, input logic [7:0] row);
    while (!calm() && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, row, col, data, off};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note(kind, off, data, col, row);
  endtask

  task automatic fill_if_blank(input logic [12:0] a);
    if (!book.written[a])
      send_req(KIND_WRITE, a, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a render request, preceded by writes of any byte it would fetch unwritten
  task automatic render(input logic [7:0] col, input logic [7:0] row);
    logic [12:0] map_a, row_a;
    logic [2:0]  b;
    if (int'(col) < LINE_WIDTH) begin
      book.locate(col, row, map_a, row_a, b);
      fill_if_blank(map_a);
      book.locate(col, row, map_a, row_a, b);
      fill_if_blank(row_a);
      fill_if_blank(row_a + 13'd1);
    end
    send_req(KIND_RENDER, 13'($urandom), 8'($urandom), col, row);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    book.regs[idx] = val;
    book.n_cfg++;
  endtask

  task automatic set_config(input logic [7:0] vals [NUM_REGS]);
    s_axis_tvalid <= 1'b0;
    while (book.pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), vals[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random backpressure, always ready in the calm window, one long hold to fill the pipeline
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check(pixel_t'(m_axis_tdata));
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && book.n_in >= HOLD_AT) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (calm()) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("timeout: no request or pixel moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] cfg [NUM_REGS];
    int         roll;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window off, low background map, unsigned tile data
    send_req(KIND_WRITE, 13'h0000, 8'h00, 8'hFF, 8'hFF);
    send_req(KIND_WRITE, 13'h1FFF, 8'hFF, 8'h00, 8'h00);
    render(8'd0, 8'd0);
    render(8'd159, 8'd143);
    render(8'd160, 8'd0);
    render(8'd255, 8'd255);
    render(8'd0, 8'd255);

    // window from column 0 and line 10, high maps, signed data, scroll wraps
    cfg = '{8'h68, 8'hFF, 8'hFF, 8'd10, 8'd7, 8'hE4};
    set_config(cfg);
    render(8'd0, 8'd9);
    render(8'd0, 8'd10);
    render(8'd159, 8'd143);
    render(8'd80, 8'd200);

    // window x below seven wraps the start past the visible line
    cfg = '{8'hB0, 8'h00, 8'h00, 8'h00, 8'd3, 8'h1B};
    set_config(cfg);
    render(8'd0, 8'd0);
    render(8'd159, 8'd0);
    render(8'd100, 8'd50);

    // window only on the last column of line 255
    cfg = '{8'h78, 8'h80, 8'h7F, 8'hFF, 8'd166, 8'h39};
    set_config(cfg);
    render(8'd159, 8'd255);
    render(8'd158, 8'd255);

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        roll = $urandom_range(3);
        cfg[i] = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom);
      end
      set_config(cfg);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 15)
          send_req(KIND_WRITE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 25)
          render(8'($urandom), 8'($urandom));
        else
          render(8'($urandom_range(LINE_WIDTH - 1)), 8'($urandom_range(143)));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (book.pixel_q.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d memory writes, %0d renders) and %0d register writes",
             book.n_in, book.n_write, book.n_render, book.n_cfg);
    $display("checked %0d pixels over background, window and wrapped settings",
             book.n_pixel);
    if (book.n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
